[src/svdp_pkg.sv]
// shared constants, types and functions for the noisy van der pol stepper
// holds the control-store layout and the microprogram itself
// no dependencies
`default_nettype none

package svdp_pkg;

	// storage and number format
	localparam int MAX_STEPS = 1024;
	localparam int FRAC_BITS = 24;
	localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	// fixed field widths
	localparam int D_W = 32;
	localparam int CNT_W = 32;
	localparam int STEP_OUT_W = 10;
	localparam int ALPHA_W = 27;
	localparam int DT_W = 25;
	localparam int SIG_W = 31;
	localparam int LAST_W = 10;
	localparam int ADDR_W = 5;
	localparam int PDATA_W = 32;

	// datapath widths
	localparam int OP_W = D_W + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int FIX_W = PROD_W - FRAC_BITS;
	localparam int SQ_W = 2 * FRAC_BITS - 1;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (LAST_W > STEP_W) ? LAST_W : STEP_W;
	localparam int PC_W = 4;

	// saturation bounds
	localparam logic signed [D_W-1:0] DATA_MAX = {1'b0, {(D_W-1){1'b1}}};
	localparam logic signed [D_W-1:0] DATA_MIN = {1'b1, {(D_W-1){1'b0}}};
	localparam logic signed [D_W:0] SUM_MAX = {1'b0, DATA_MAX};
	localparam logic signed [D_W:0] SUM_MIN = {1'b1, DATA_MIN};
	localparam logic signed [FIX_W-1:0] FIX_MAX = {{(FIX_W-D_W){1'b0}}, DATA_MAX};
	localparam logic signed [FIX_W-1:0] FIX_MIN = {{(FIX_W-D_W){1'b1}}, DATA_MIN};

	// sink test bounds: half a unit, and half a unit squared
	localparam logic signed [OP_W-1:0] HALF_P = OP_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [OP_W-1:0] HALF_N = -HALF_P;
	localparam logic [SUM_W-1:0] HIT_LIM = SUM_W'(1) << (2 * FRAC_BITS - 2);

	// register map
	localparam logic [ADDR_W-3:0] REG_SINK_OFFSET = 3'd0;
	localparam logic [ADDR_W-3:0] REG_TIME_STEP = 3'd1;
	localparam logic [ADDR_W-3:0] REG_ROOT_TIME_STEP = 3'd2;
	localparam logic [ADDR_W-3:0] REG_NOISE_STRENGTH = 3'd3;
	localparam logic [ADDR_W-3:0] REG_LAST_STEP = 3'd4;

	// register reset values
	localparam logic [ALPHA_W-1:0] RST_SINK_OFFSET = 27'd16777216;
	localparam logic [DT_W-1:0] RST_TIME_STEP = 25'd167772;
	localparam logic [DT_W-1:0] RST_ROOT_TIME_STEP = 25'd1677722;
	localparam logic [SIG_W-1:0] RST_NOISE_STRENGTH = 31'd0;
	localparam logic [LAST_W-1:0] RST_LAST_STEP = 10'd1023;

	typedef struct packed {
		logic [ALPHA_W-1:0] sink_offset;
		logic [DT_W-1:0]    time_step;
		logic [DT_W-1:0]    root_time_step;
		logic [SIG_W-1:0]   noise_strength;
		logic [LAST_W-1:0]  last_step;
	} cfg_t;

	// control word fields
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_WAIT_OUT,
		SEQ_JUMP
	} seq_t;

	typedef enum logic [2:0] {
		OPA_ZERO,
		OPA_X,
		OPA_Y,
		OPA_ALPHA,
		OPA_SIGMA,
		OPA_T0,
		OPA_T1,
		OPA_DX
	} opa_t;

	typedef enum logic [2:0] {
		OPB_ZERO,
		OPB_X,
		OPB_Y,
		OPB_ALPHA,
		OPB_DT,
		OPB_RDT,
		OPB_NOISE,
		OPB_DX
	} opb_t;

	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_FIX_T0,
		ALU_FIX_T1,
		ALU_T0_SUB_FIX,
		ALU_FIX_SUB_Y,
		ALU_T0_ADD_FIX,
		ALU_UPDATE,
		ALU_DIST,
		ALU_SQ,
		ALU_HIT
	} alu_t;

	typedef struct packed {
		seq_t            seq;
		logic            mul;
		opa_t            opa;
		opb_t            opb;
		alu_t            alu;
		logic [PC_W-1:0] target;
	} cw_t;

	// sequencer to histogram and result register
	typedef struct packed {
		logic              fin;
		logic              oot;
		logic [STEP_W-1:0] idx;
	} res_ctl_t;

	// microprogram addresses
	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_MUL_AA = 4'd1;
	localparam logic [PC_W-1:0] PC_MUL_XX = 4'd2;
	localparam logic [PC_W-1:0] PC_MUL_SX = 4'd3;
	localparam logic [PC_W-1:0] PC_MUL_TX = 4'd4;
	localparam logic [PC_W-1:0] PC_MUL_SR = 4'd5;
	localparam logic [PC_W-1:0] PC_MUL_DDT = 4'd6;
	localparam logic [PC_W-1:0] PC_MUL_SN = 4'd7;
	localparam logic [PC_W-1:0] PC_MUL_YDT = 4'd8;
	localparam logic [PC_W-1:0] PC_UPDATE = 4'd9;
	localparam logic [PC_W-1:0] PC_MUL_YY = 4'd10;
	localparam logic [PC_W-1:0] PC_MUL_DXDX = 4'd11;
	localparam logic [PC_W-1:0] PC_HIT = 4'd12;
	localparam logic [PC_W-1:0] PC_FIN = 4'd13;

	// control store; an alu operation that uses a product takes the one made in the step before
	function automatic cw_t ucode(input logic [PC_W-1:0] pc);
		cw_t w;
		w = '{seq: SEQ_NEXT, mul: 1'b0, opa: OPA_ZERO, opb: OPB_ZERO,
			alu: ALU_NONE, target: PC_IDLE};
		case (pc)
			PC_IDLE: begin
				w.seq = SEQ_WAIT_IN;
				w.target = PC_FIN;
			end
			PC_MUL_AA: begin
				w.mul = 1'b1; w.opa = OPA_ALPHA; w.opb = OPB_ALPHA;
			end
			PC_MUL_XX: begin
				w.alu = ALU_FIX_T0;
				w.mul = 1'b1; w.opa = OPA_X; w.opb = OPB_X;
			end
			PC_MUL_SX: begin
				w.alu = ALU_T0_SUB_FIX;
				w.mul = 1'b1; w.opa = OPA_SIGMA; w.opb = OPB_X;
			end
			PC_MUL_TX: begin
				w.alu = ALU_FIX_T1;
				w.mul = 1'b1; w.opa = OPA_T0; w.opb = OPB_X;
			end
			PC_MUL_SR: begin
				w.alu = ALU_FIX_SUB_Y;
				w.mul = 1'b1; w.opa = OPA_T1; w.opb = OPB_RDT;
			end
			PC_MUL_DDT: begin
				w.alu = ALU_FIX_T1;
				w.mul = 1'b1; w.opa = OPA_T0; w.opb = OPB_DT;
			end
			PC_MUL_SN: begin
				w.alu = ALU_FIX_T0;
				w.mul = 1'b1; w.opa = OPA_T1; w.opb = OPB_NOISE;
			end
			PC_MUL_YDT: begin
				w.alu = ALU_T0_ADD_FIX;
				w.mul = 1'b1; w.opa = OPA_Y; w.opb = OPB_DT;
			end
			PC_UPDATE: begin
				w.alu = ALU_UPDATE;
			end
			PC_MUL_YY: begin
				w.alu = ALU_DIST;
				w.mul = 1'b1; w.opa = OPA_Y; w.opb = OPB_Y;
			end
			PC_MUL_DXDX: begin
				w.alu = ALU_SQ;
				w.mul = 1'b1; w.opa = OPA_DX; w.opb = OPB_DX;
			end
			PC_HIT: begin
				w.alu = ALU_HIT;
			end
			PC_FIN: begin
				w.seq = SEQ_WAIT_OUT;
				w.target = PC_IDLE;
			end
			default: begin
				w.seq = SEQ_JUMP;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

	// saturate a sum of two data words
	function automatic logic signed [D_W-1:0] sat_sum(input logic signed [D_W:0] s);
		if (s > SUM_MAX) return DATA_MAX;
		if (s < SUM_MIN) return DATA_MIN;
		return s[D_W-1:0];
	endfunction

	// floor a product to the fraction point, then saturate
	function automatic logic signed [D_W-1:0] fix_prod(input logic signed [PROD_W-1:0] p);
		logic signed [FIX_W-1:0] s;
		s = p[PROD_W-1:FRAC_BITS];
		if (s > FIX_MAX) return DATA_MAX;
		if (s < FIX_MIN) return DATA_MIN;
		return s[D_W-1:0];
	endfunction

	// last step clamped to the histogram depth
	function automatic logic [STEP_W-1:0] eff_last(input logic [LAST_W-1:0] ls);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(ls);
		b = CMP_W'(MAX_STEPS - 1);
		return (a > b) ? STEP_W'(b) : STEP_W'(a);
	endfunction

endpackage

`default_nettype wire

[src/svdp_if.sv]
// request and result channel interfaces for the stepper
// depends on svdp_pkg
`default_nettype none

interface svdp_item_if;
	import svdp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  start_trial;
	logic signed [D_W-1:0] initial_pos;
	logic signed [D_W-1:0] noise_sample;
	modport source(output valid, start_trial, initial_pos, noise_sample, input ready);
	modport sink(input valid, start_trial, initial_pos, noise_sample, output ready);
endinterface

interface svdp_result_if;
	import svdp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [STEP_OUT_W-1:0] step_index;
	logic signed [D_W-1:0] pos_out;
	logic signed [D_W-1:0] vel_out;
	logic                  near_sink;
	logic [CNT_W-1:0]      hit_total;
	logic                  out_of_trial;
	modport source(output valid, step_index, pos_out, vel_out, near_sink, hit_total,
		out_of_trial, input ready);
	modport sink(input valid, step_index, pos_out, vel_out, near_sink, hit_total,
		out_of_trial, output ready);
endinterface

`default_nettype wire

[src/svdp_seq.sv]
// microcode sequencer: step counter, control store lookup, trial bookkeeping
// depends on svdp_pkg
`default_nettype none

module svdp_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          start_trial,
	input  wire logic                          res_free,
	input  wire logic                          clr_done,
	input  wire logic [svdp_pkg::LAST_W-1:0]   last_step,
	output svdp_pkg::cw_t                      cw,
	output svdp_pkg::res_ctl_t                 rctl
);
	import svdp_pkg::*;

	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   pc_next;
	logic              running_q;
	logic [STEP_W-1:0] cur_q;
	logic [STEP_W-1:0] idx_q;
	logic              oot_q;
	logic              accept;
	logic              oot_now;
	logic              fin;
	logic [STEP_W-1:0] lim;
	logic [STEP_W-1:0] cur;
	logic [STEP_W-1:0] idx;

	// control word for this step
	assign cw = ucode(pc_q);

	// handshake decode
	assign item_ready = (cw.seq == SEQ_WAIT_IN) && clr_done;
	assign accept = item_valid && item_ready;
	assign oot_now = !start_trial && !running_q;
	assign fin = (cw.seq == SEQ_WAIT_OUT) && res_free;

	// step index of the incoming request
	assign lim = eff_last(last_step);
	assign cur = start_trial ? '0 : cur_q;
	assign idx = (cur > lim) ? lim : cur;

	// next step address
	always_comb begin
		pc_next = pc_q + PC_W'(1);
		unique case (cw.seq)
			SEQ_NEXT: pc_next = pc_q + PC_W'(1);
			SEQ_WAIT_IN: begin
				if (!accept) pc_next = pc_q;
				else if (oot_now) pc_next = cw.target;
				else pc_next = pc_q + PC_W'(1);
			end
			SEQ_WAIT_OUT: pc_next = fin ? cw.target : pc_q;
			SEQ_JUMP: pc_next = cw.target;
			default: pc_next = PC_IDLE;
		endcase
	end

	// step counter and trial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			running_q <= 1'b0;
			cur_q <= '0;
			idx_q <= '0;
			oot_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (accept) begin
				oot_q <= oot_now;
				idx_q <= idx;
				if (start_trial) running_q <= 1'b1;
			end
			if (fin && !oot_q) begin
				if (idx_q >= lim) begin
					running_q <= 1'b0;
					cur_q <= idx_q;
				end else begin
					cur_q <= idx_q + STEP_W'(1);
				end
			end
		end
	end

	assign rctl = '{fin: fin, oot: oot_q, idx: idx_q};

endmodule

`default_nettype wire

[src/svdp_dp.sv]
// datapath: shared multiplier, floor and saturate unit, state and temporaries
// depends on svdp_pkg; driven by control words from svdp_seq
`default_nettype none

module svdp_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire svdp_pkg::cw_t                cw,
	input  wire svdp_pkg::cfg_t               cfg,
	input  wire logic                         load,
	input  wire logic                         start_trial,
	input  wire logic signed [svdp_pkg::D_W-1:0] initial_pos,
	input  wire logic signed [svdp_pkg::D_W-1:0] noise_sample,
	output logic signed [svdp_pkg::D_W-1:0]   pos,
	output logic signed [svdp_pkg::D_W-1:0]   vel,
	output logic                              hit
);
	import svdp_pkg::*;

	logic signed [D_W-1:0]    x_q;
	logic signed [D_W-1:0]    y_q;
	logic signed [D_W-1:0]    t0_q;
	logic signed [D_W-1:0]    t1_q;
	logic signed [D_W-1:0]    noise_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [OP_W-1:0]   dx_q;
	logic                     rng_q;
	logic [SQ_W-1:0]          sq_q;
	logic                     hit_q;

	logic signed [OP_W-1:0]   opa;
	logic signed [OP_W-1:0]   opb;
	logic signed [D_W-1:0]    fix;
	logic signed [OP_W-1:0]   xe;
	logic signed [OP_W-1:0]   ye;
	logic signed [OP_W-1:0]   ae;
	logic signed [OP_W-1:0]   dx;
	logic                     rng;
	logic [SUM_W-1:0]         dsq;

	// operand select
	always_comb begin
		case (cw.opa)
			OPA_X: opa = {x_q[D_W-1], x_q};
			OPA_Y: opa = {y_q[D_W-1], y_q};
			OPA_ALPHA: opa = OP_W'(cfg.sink_offset);
			OPA_SIGMA: opa = OP_W'(cfg.noise_strength);
			OPA_T0: opa = {t0_q[D_W-1], t0_q};
			OPA_T1: opa = {t1_q[D_W-1], t1_q};
			OPA_DX: opa = dx_q;
			default: opa = '0;
		endcase
		case (cw.opb)
			OPB_X: opb = {x_q[D_W-1], x_q};
			OPB_Y: opb = {y_q[D_W-1], y_q};
			OPB_ALPHA: opb = OP_W'(cfg.sink_offset);
			OPB_DT: opb = OP_W'(cfg.time_step);
			OPB_RDT: opb = OP_W'(cfg.root_time_step);
			OPB_NOISE: opb = {noise_q[D_W-1], noise_q};
			OPB_DX: opb = dx_q;
			default: opb = '0;
		endcase
	end

	// previous product floored and saturated
	assign fix = fix_prod(p_q);

	// offset from the nearer sink and the window check
	assign xe = {x_q[D_W-1], x_q};
	assign ye = {y_q[D_W-1], y_q};
	assign ae = OP_W'(cfg.sink_offset);
	assign dx = x_q[D_W-1] ? (xe + ae) : (xe - ae);
	assign rng = (dx >= HALF_N) && (dx <= HALF_P) && (ye >= HALF_N) && (ye <= HALF_P);

	// squared distance, exact
	assign dsq = {1'b0, sq_q} + {1'b0, p_q[SQ_W-1:0]};

	// position and velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (load && start_trial) begin
			x_q <= initial_pos;
			y_q <= '0;
		end else if (cw.alu == ALU_UPDATE) begin
			x_q <= sat_sum({x_q[D_W-1], x_q} + {fix[D_W-1], fix});
			y_q <= sat_sum({y_q[D_W-1], y_q} + {t0_q[D_W-1], t0_q});
		end
	end

	// multiplier, temporaries and sink test
	always_ff @(posedge clk) begin
		if (load) noise_q <= noise_sample;
		if (cw.mul) p_q <= opa * opb;
		case (cw.alu)
			ALU_FIX_T0: t0_q <= fix;
			ALU_FIX_T1: t1_q <= fix;
			ALU_T0_SUB_FIX: t0_q <= sat_sum({t0_q[D_W-1], t0_q} - {fix[D_W-1], fix});
			ALU_FIX_SUB_Y: t0_q <= sat_sum({fix[D_W-1], fix} - {y_q[D_W-1], y_q});
			ALU_T0_ADD_FIX: t0_q <= sat_sum({t0_q[D_W-1], t0_q} + {fix[D_W-1], fix});
			ALU_DIST: begin
				dx_q <= dx;
				rng_q <= rng;
			end
			ALU_SQ: sq_q <= p_q[SQ_W-1:0];
			ALU_HIT: hit_q <= rng_q && (dsq <= HIT_LIM);
			default: ;
		endcase
	end

	assign pos = x_q;
	assign vel = y_q;
	assign hit = hit_q;

endmodule

`default_nettype wire

[src/svdp_hist.sv]
// per-step hit counters in a memory with one write port and one read port, with a clearing pass after reset
// depends on svdp_pkg
`default_nettype none

module svdp_hist (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire svdp_pkg::res_ctl_t       rctl,
	input  wire logic                     hit,
	output logic [svdp_pkg::CNT_W-1:0]    count,
	output logic                          clr_done
);
	import svdp_pkg::*;

	logic [CNT_W-1:0]  mem [MAX_STEPS];
	logic [CNT_W-1:0]  rd_q;
	logic              clr_busy_q;
	logic [STEP_W-1:0] clr_addr_q;
	logic              we;
	logic [STEP_W-1:0] wa;
	logic [CNT_W-1:0]  wd;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == STEP_W'(MAX_STEPS - 1)) clr_busy_q <= 1'b0;
			else clr_addr_q <= clr_addr_q + STEP_W'(1);
		end
	end

	assign clr_done = !clr_busy_q;

	// updated count, held at all ones
	assign count = (hit && (rd_q != '1)) ? rd_q + CNT_W'(1) : rd_q;

	// write port shared by the sweep and the update
	assign we = clr_busy_q || (rctl.fin && !rctl.oot);
	assign wa = clr_busy_q ? clr_addr_q : rctl.idx;
	assign wd = clr_busy_q ? '0 : count;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[rctl.idx];
	end

endmodule

`default_nettype wire

[src/stochastic_vdp_step_histogram_top.sv]
// top level: configuration registers, result register and block wiring
// depends on svdp_pkg, svdp_if, svdp_seq, svdp_dp, svdp_hist
`default_nettype none

// One Euler-Maruyama step of a noisy Van der Pol oscillator per request, in
// signed Q8.24 with floor rounding and 32-bit saturation, followed by a test
// against the sinks at plus and minus sink_offset and a saturating per-step hit
// count. A single shared 33x33 multiplier, driven by a 14-step microprogram,
// does all ten products. A request outside a trial goes from the idle word
// straight to the last word, with no computation. No new request is taken
// until the result of the one before has moved to the output register. A step
// waits in its last microprogram word while the previous result is still held.
// After reset the counter memory is cleared one entry per cycle, so no request
// is taken until that pass is done; configuration writes are taken at any time.
// A finished result sits in an output register, so the next request is taken
// while it waits.
module stochastic_vdp_step_histogram_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	svdp_item_if.sink                          item,
	svdp_result_if.source                      result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [svdp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [svdp_pkg::PDATA_W-1:0]  pwdata,
	output logic [svdp_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);
	import svdp_pkg::*;

	cfg_t                  cfg_q;
	cw_t                   cw;
	res_ctl_t              rctl;
	logic                  item_ready;
	logic                  load;
	logic                  res_free;
	logic                  clr_done;
	logic signed [D_W-1:0] pos;
	logic signed [D_W-1:0] vel;
	logic                  hit;
	logic [CNT_W-1:0]      count;
	logic [ADDR_W-3:0]     reg_idx;
	logic                  res_valid_q;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sink_offset <= RST_SINK_OFFSET;
			cfg_q.time_step <= RST_TIME_STEP;
			cfg_q.root_time_step <= RST_ROOT_TIME_STEP;
			cfg_q.noise_strength <= RST_NOISE_STRENGTH;
			cfg_q.last_step <= RST_LAST_STEP;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SINK_OFFSET: cfg_q.sink_offset <= pwdata[ALPHA_W-1:0];
				REG_TIME_STEP: cfg_q.time_step <= pwdata[DT_W-1:0];
				REG_ROOT_TIME_STEP: cfg_q.root_time_step <= pwdata[DT_W-1:0];
				REG_NOISE_STRENGTH: cfg_q.noise_strength <= pwdata[SIG_W-1:0];
				REG_LAST_STEP: cfg_q.last_step <= pwdata[LAST_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_SINK_OFFSET: prdata = PDATA_W'(cfg_q.sink_offset);
			REG_TIME_STEP: prdata = PDATA_W'(cfg_q.time_step);
			REG_ROOT_TIME_STEP: prdata = PDATA_W'(cfg_q.root_time_step);
			REG_NOISE_STRENGTH: prdata = PDATA_W'(cfg_q.noise_strength);
			REG_LAST_STEP: prdata = PDATA_W'(cfg_q.last_step);
			default: prdata = '0;
		endcase
	end

	// request side
	assign item.ready = item_ready;
	assign load = item.valid && item_ready;
	assign res_free = !res_valid_q || result.ready;

	svdp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item_ready),
		.start_trial (item.start_trial),
		.res_free    (res_free),
		.clr_done    (clr_done),
		.last_step   (cfg_q.last_step),
		.cw          (cw),
		.rctl        (rctl)
	);

	svdp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cw           (cw),
		.cfg          (cfg_q),
		.load         (load),
		.start_trial  (item.start_trial),
		.initial_pos  (item.initial_pos),
		.noise_sample (item.noise_sample),
		.pos          (pos),
		.vel          (vel),
		.hit          (hit)
	);

	svdp_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.rctl     (rctl),
		.hit      (hit && !rctl.oot),
		.count    (count),
		.clr_done (clr_done)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rctl.fin) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload; an ignored request reports zeros and sets out_of_trial
	always_ff @(posedge clk) begin
		if (rctl.fin) begin
			result.step_index <= rctl.oot ? '0 : STEP_OUT_W'(rctl.idx);
			result.pos_out <= rctl.oot ? '0 : pos;
			result.vel_out <= rctl.oot ? '0 : vel;
			result.near_sink <= hit && !rctl.oot;
			result.hit_total <= rctl.oot ? '0 : count;
			result.out_of_trial <= rctl.oot;
		end
	end

	assign result.valid = res_valid_q;

endmodule

`default_nettype wire

[dv/stochastic_vdp_step_histogram_top_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the noisy van der pol stepper and its per-step hit histogram
// predicts each result in a small class and compares field by field; needs svdp_pkg, svdp_if
// and stochastic_vdp_step_histogram_top

module stochastic_vdp_step_histogram_top_test;
	import svdp_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	localparam logic signed [D_W-1:0] ONE = 32'sd16777216;

	typedef struct {
		logic [STEP_OUT_W-1:0] step_index;
		logic signed [D_W-1:0] pos_out;
		logic signed [D_W-1:0] vel_out;
		logic                  near_sink;
		logic [CNT_W-1:0]      hit_total;
		logic                  out_of_trial;
	} step_result_t;

	// oscillator state, hit histogram and the results still owed by the block
	class oscillator_ledger;
		cfg_t                  regs;
		logic signed [D_W-1:0] pos;
		logic signed [D_W-1:0] vel;
		logic [STEP_W-1:0]     cur_step;
		bit                    running;
		logic [CNT_W-1:0]      hits [MAX_STEPS];
		step_result_t          due_steps [$];
		int                    errors;

		function new();
			regs.sink_offset = RST_SINK_OFFSET;
			regs.time_step = RST_TIME_STEP;
			regs.root_time_step = RST_ROOT_TIME_STEP;
			regs.noise_strength = RST_NOISE_STRENGTH;
			regs.last_step = RST_LAST_STEP;
			pos = '0;
			vel = '0;
			cur_step = '0;
			running = 0;
			errors = 0;
			foreach (hits[i]) hits[i] = '0;
		endfunction

		// store a register write, return the value a read should give
		function logic [PDATA_W-1:0] set_reg(logic [ADDR_W-3:0] idx, logic [PDATA_W-1:0] v);
			case (idx)
				REG_SINK_OFFSET: begin
					regs.sink_offset = v[ALPHA_W-1:0];
					return PDATA_W'(regs.sink_offset);
				end
				REG_TIME_STEP: begin
					regs.time_step = v[DT_W-1:0];
					return PDATA_W'(regs.time_step);
				end
				REG_ROOT_TIME_STEP: begin
					regs.root_time_step = v[DT_W-1:0];
					return PDATA_W'(regs.root_time_step);
				end
				REG_NOISE_STRENGTH: begin
					regs.noise_strength = v[SIG_W-1:0];
					return PDATA_W'(regs.noise_strength);
				end
				REG_LAST_STEP: begin
					regs.last_step = v[LAST_W-1:0];
					return PDATA_W'(regs.last_step);
				end
				default: return '0;
			endcase
		endfunction

		function int outstanding();
			return due_steps.size();
		endfunction

		function bit trial_active();
			return running;
		endfunction

		function logic signed [D_W-1:0] clip32(longint v);
			if (v > longint'(DATA_MAX)) return DATA_MAX;
			if (v < longint'(DATA_MIN)) return DATA_MIN;
			return v[D_W-1:0];
		endfunction

		// product floored to the fraction point, then saturated
		function logic signed [D_W-1:0] qmul(longint a, longint b);
			longint p;
			p = a * b;
			return clip32(p >>> FRAC_BITS);
		endfunction

		// exact test for lying within half a unit of (cx, 0)
		function bit by_sink(longint x, longint y, longint cx);
			longint half;
			longint dx;
			half = longint'(1) << (FRAC_BITS - 1);
			dx = x - cx;
			if (dx > half || dx < -half || y > half || y < -half) return 0;
			return (dx * dx + y * y) <= (longint'(1) << (2 * FRAC_BITS - 2));
		endfunction

		// one accepted request: advance the oscillator and queue the result it owes
		function void take_request(bit st, logic signed [D_W-1:0] ipos,
			logic signed [D_W-1:0] nz);
			step_result_t r;
			longint x, y, alpha, dt;
			logic signed [D_W-1:0] a2, x2, t, c, d, d1, s1, s2, d2, xn, yn;
			int unsigned lim, idx;
			bit hit;
			r.step_index = '0;
			r.pos_out = '0;
			r.vel_out = '0;
			r.near_sink = 1'b0;
			r.hit_total = '0;
			r.out_of_trial = 1'b1;
			if (st) begin
				pos = ipos;
				vel = '0;
				cur_step = '0;
				running = 1;
			end
			// outside a trial nothing moves
			if (!running) begin
				due_steps.push_back(r);
				return;
			end
			x = longint'(pos);
			y = longint'(vel);
			alpha = longint'(regs.sink_offset);
			dt = longint'(regs.time_step);
			a2 = qmul(alpha, alpha);
			x2 = qmul(x, x);
			t = clip32(longint'(a2) - longint'(x2));
			c = qmul(longint'(t), x);
			d = clip32(longint'(c) - y);
			d1 = qmul(longint'(d), dt);
			s1 = qmul(longint'(regs.noise_strength), x);
			s2 = qmul(longint'(s1), longint'(regs.root_time_step));
			d2 = qmul(longint'(s2), longint'(nz));
			xn = clip32(x + longint'(qmul(y, dt)));
			yn = clip32(y + longint'(clip32(longint'(d1) + longint'(d2))));
			pos = xn;
			vel = yn;
			// step index clamped to the effective last step
			lim = regs.last_step;
			if (lim > MAX_STEPS - 1) lim = MAX_STEPS - 1;
			idx = cur_step;
			if (idx > lim) idx = lim;
			hit = by_sink(longint'(xn), longint'(yn), alpha)
				|| by_sink(longint'(xn), longint'(yn), -alpha);
			if (hit && hits[idx] != '1) hits[idx] = hits[idx] + 1;
			r.step_index = idx[STEP_OUT_W-1:0];
			r.pos_out = xn;
			r.vel_out = yn;
			r.near_sink = hit;
			r.hit_total = hits[idx];
			r.out_of_trial = 1'b0;
			if (idx >= lim) begin
				running = 0;
				cur_step = idx[STEP_W-1:0];
			end else begin
				cur_step = STEP_W'(idx + 1);
			end
			due_steps.push_back(r);
		endfunction

		// compare one accepted result with the oldest one owed
		function void match_result(step_result_t got);
			step_result_t w;
			if (due_steps.size() == 0) begin
				$error("result accepted with no request outstanding");
				errors++;
				return;
			end
			w = due_steps.pop_front();
			if (got.step_index !== w.step_index) begin
				$error("step_index expected %0d actual %0d", w.step_index, got.step_index);
				errors++;
			end
			if (got.pos_out !== w.pos_out) begin
				$error("pos_out expected %0d actual %0d", w.pos_out, got.pos_out);
				errors++;
			end
			if (got.vel_out !== w.vel_out) begin
				$error("vel_out expected %0d actual %0d", w.vel_out, got.vel_out);
				errors++;
			end
			if (got.near_sink !== w.near_sink) begin
				$error("near_sink expected %0d actual %0d", w.near_sink, got.near_sink);
				errors++;
			end
			if (got.hit_total !== w.hit_total) begin
				$error("hit_total expected %0d actual %0d", w.hit_total, got.hit_total);
				errors++;
			end
			if (got.out_of_trial !== w.out_of_trial) begin
				$error("out_of_trial expected %0d actual %0d", w.out_of_trial,
					got.out_of_trial);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	svdp_item_if   item_ch();
	svdp_result_if result_ch();

	oscillator_ledger ledger = new();
	int apb_errors = 0;
	bit idle_on = 1;
	int rx_hold = 0;

	stochastic_vdp_step_histogram_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(2_000_000);
		$display("stochastic_vdp_step_histogram_top_test: errors");
		$finish;
	end

	// apb write, then read back the same register
	task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] stored;
		stored = ledger.set_reg(idx, val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== stored) begin
			$error("register %0d expected %0h actual %0h", idx, stored, prdata);
			apb_errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one request and wait until it is taken
	task automatic send_request(input bit st, input logic signed [D_W-1:0] ipos,
		input logic signed [D_W-1:0] nz);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.start_trial <= st;
		item_ch.initial_pos <= ipos;
		item_ch.noise_sample <= nz;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		ledger.take_request(st, ipos, nz);
	endtask

	// stop offering and let every owed result come out
	task automatic wait_drain();
		item_ch.valid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		step_result_t got;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = idle_on ? $urandom_range(0, 10) : 0;
			end
			if (n > 0) begin
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.step_index = result_ch.step_index;
			got.pos_out = result_ch.pos_out;
			got.vel_out = result_ch.vel_out;
			got.near_sink = result_ch.near_sink;
			got.hit_total = result_ch.hit_total;
			got.out_of_trial = result_ch.out_of_trial;
			ledger.match_result(got);
		end
	end

	// stimulus
	initial begin
		int r;
		int a;
		bit st;
		logic signed [D_W-1:0] ipos;
		logic signed [D_W-1:0] nz;
		logic [PDATA_W-1:0] v;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.start_trial <= 1'b0;
		item_ch.initial_pos <= '0;
		item_ch.noise_sample <= '0;
		result_ch.ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: requests before any trial, sink starts, saturated starts
		send_request(1'b0, DATA_MAX, DATA_MIN);
		send_request(1'b0, '0, '0);
		send_request(1'b1, ONE, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b1, -ONE + 32'sd4194304, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b1, DATA_MAX, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b1, DATA_MIN, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b0, '0, '0);
		wait_drain();

		// offset, noise at top, time steps at one; trial is past the new last step
		write_reg(REG_SINK_OFFSET, 32'd134217727);
		write_reg(REG_TIME_STEP, 32'd16777216);
		write_reg(REG_ROOT_TIME_STEP, 32'd16777216);
		write_reg(REG_NOISE_STRENGTH, 32'd2147483647);
		write_reg(REG_LAST_STEP, 32'd2);
		send_request(1'b0, '0, DATA_MAX);
		send_request(1'b0, -32'sd1, 32'sd1);
		send_request(1'b1, ONE, DATA_MIN);
		send_request(1'b0, '0, -32'sd1);
		send_request(1'b1, -ONE, 32'sh55555555);
		send_request(1'b0, 32'sh2AAAAAAA, 32'shAAAAAAAA);
		send_request(1'b0, '0, '0);
		wait_drain();

		// all registers at zero: single-step trials
		write_reg(REG_SINK_OFFSET, 32'd0);
		write_reg(REG_TIME_STEP, 32'd0);
		write_reg(REG_ROOT_TIME_STEP, 32'd0);
		write_reg(REG_NOISE_STRENGTH, 32'd0);
		write_reg(REG_LAST_STEP, 32'd0);
		send_request(1'b1, ONE, '0);
		send_request(1'b0, '0, '0);
		send_request(1'b1, -32'sd1, -32'sd1);
		send_request(1'b1, '0, DATA_MAX);
		wait_drain();

		// random phases, each with its own settings
		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_on = (p % 3) != 1;
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = 32'd134217727;
				2: v = $urandom_range(0, 134217727);
				default: v = 32'd14680064 + $urandom_range(0, 4194304);
			endcase
			write_reg(REG_SINK_OFFSET, v);
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = 32'd16777216;
				2: v = $urandom_range(0, 33554431);
				default: v = $urandom_range(16777, 1677722);
			endcase
			write_reg(REG_TIME_STEP, v);
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = 32'd16777216;
				2: v = $urandom_range(0, 33554431);
				default: v = $urandom_range(0, 5305000);
			endcase
			write_reg(REG_ROOT_TIME_STEP, v);
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = 32'd2147483647;
				2: v = $urandom_range(0, 2147483647);
				default: v = $urandom_range(0, 8388608);
			endcase
			write_reg(REG_NOISE_STRENGTH, v);
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = 32'd1023;
				2: v = 32'd1;
				default: v = $urandom_range(2, 40);
			endcase
			write_reg(REG_LAST_STEP, v);

			// long result hold-off while requests keep coming
			if (p == 3) rx_hold = 400;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// one pause until the block is empty
				if (p == 6 && k == PHASE_ITEMS / 2) wait_drain();
				// mostly whole trials, sometimes a restart or a stray request
				r = $urandom_range(0, 99);
				st = ledger.trial_active() ? (r < 3) : (r >= 8);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						a = int'(ledger.regs.sink_offset);
						if ($urandom_range(0, 1)) a = -a;
						ipos = a + $urandom_range(0, 20132658) - 10066329;
					end
					6: ipos = $urandom;
					7: ipos = $urandom_range(0, 67108864) - 33554432;
					8: ipos = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
					default: ipos = '0;
				endcase
				nz = ($urandom_range(0, 7) == 0) ? $urandom
					: $urandom_range(0, 100663296) - 50331648;
				send_request(st, ipos, nz);
			end
			wait_drain();
		end

		if (ledger.errors == 0 && apb_errors == 0 && ledger.outstanding() == 0) begin
			$display("stochastic_vdp_step_histogram_top_test: clean");
		end else begin
			$display("stochastic_vdp_step_histogram_top_test: errors");
		end
		$finish;
	end

endmodule
